// File: sv/mbd_pkg.sv
// Shared types and constants for the multi-button debouncer with its press-event queue.
// This package has no dependencies. The top level refers to it by scoped names.
package mbd_pkg;

   localparam int LEVEL_BITS = 5;
   localparam int NOW_W      = 32;
   localparam int DEB_W      = 16;
   localparam int BTN_W      = 3;
   localparam int MODE_W     = 2;
   localparam int REQ_W      = 40;
   localparam int CSR_IDX_W  = 1;

   localparam logic [DEB_W-1:0] DEB_RESET = 16'd35;
   localparam logic             ACTIVE_LOW_RESET = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_LOW = 1'd1;

   typedef enum logic [MODE_W-1:0] {
      MODE_TICK = 2'd0,
      MODE_POP  = 2'd1,
      MODE_INIT = 2'd2,
      MODE_NOP  = 2'd3
   } mode_type;

endpackage

// File: sv/multi_button_debounce_event_fifo.sv
// Top level of the multi-button debouncer with its press-event queue; depends on mbd_pkg.
// A tick walks over the buttons through the change-time memory, an initialise writes
// each button's change time, and a pop takes the head of the queue; each then ends in
// ST_DONE, as does a pop on an empty queue or the unused mode 3. A new request is taken
// only in ST_IDLE, and ST_DONE holds the result back while an earlier one is unaccepted.
// Reset is synchronous and clears button states, change-time valid flags, queue pointers and count.
module multi_button_debounce_event_fifo #(
   parameter int NUM_BUTTONS = 5,
   parameter int QUEUE_DEPTH = 8,
   localparam int CW    = $clog2(QUEUE_DEPTH + 1),
   localparam int RSP_W = ((CW + 5 + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   // Input transaction.
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [mbd_pkg::REQ_W-1:0]     req_tdata,   // now_ms[31:0], raw_levels[36:32]
   input  logic [mbd_pkg::MODE_W-1:0]    req_tuser,   // mode[1:0]
   // Result transaction.
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [RSP_W-1:0]              rsp_tdata,   // event_valid, event_button,
                                                      // events_waiting, overflow
   // Register writes.
   input  logic                          csr_we,
   input  logic [mbd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mbd_pkg::DEB_W-1:0]     csr_wdata
);

   localparam int IW  = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
   localparam int BCW = $clog2(NUM_BUTTONS + 1);
   localparam int PW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK,
      ST_INIT,
      ST_POP,
      ST_DONE
   } state_type;

   state_type                    state_ff, state_in;
   logic [BCW-1:0]               btn_ff, btn_in;
   logic                         pvld_ff, pvld_in;
   logic [IW-1:0]                pidx_ff, pidx_in;
   logic [mbd_pkg::NOW_W-1:0]    now_ff, now_in;
   logic [mbd_pkg::LEVEL_BITS-1:0] lvl_ff, lvl_in;
   logic                         drop_ff, drop_in;
   logic [NUM_BUTTONS-1:0]       raw_ff, raw_in;
   logic [NUM_BUTTONS-1:0]       stable_ff, stable_in;
   logic [NUM_BUTTONS-1:0]       ct_vld_ff, ct_vld_in;
   logic [PW-1:0]                rp_ff, rp_in;
   logic [PW-1:0]                wp_ff, wp_in;
   logic [CW-1:0]                count_ff, count_in;
   logic                         res_valid_ff, res_valid_in;
   logic [mbd_pkg::BTN_W-1:0]    res_button_ff, res_button_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_evalid_ff, rsp_evalid_in;
   logic [mbd_pkg::BTN_W-1:0]    rsp_button_ff, rsp_button_in;
   logic [CW-1:0]                rsp_count_ff, rsp_count_in;
   logic                         rsp_ovf_ff, rsp_ovf_in;
   logic [mbd_pkg::DEB_W-1:0]    deb_ff;
   logic                         active_low_ff;

   logic [mbd_pkg::NOW_W-1:0]    ct_mem [NUM_BUTTONS];
   logic [mbd_pkg::NOW_W-1:0]    ct_q;
   logic                         ct_re;
   logic                         ct_we;
   logic [IW-1:0]                ct_waddr;
   logic [mbd_pkg::BTN_W-1:0]    ev_mem [QUEUE_DEPTH];
   logic [mbd_pkg::BTN_W-1:0]    ev_q;
   logic                         ev_we;

   logic [NUM_BUTTONS-1:0]       pin_press;
   logic                         p_cur;
   logic                         chg;
   logic [mbd_pkg::NOW_W-1:0]    t_old;
   logic [mbd_pkg::NOW_W-1:0]    t_eff;
   logic [mbd_pkg::NOW_W-1:0]    elapsed;
   logic                         settle;
   logic                         push;
   logic                         full;
   logic                         out_free;
   logic [PW-1:0]                wp_next;
   logic [PW-1:0]                rp_next;

   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_pin
      if (i < mbd_pkg::LEVEL_BITS) begin : g_lvl
         assign pin_press[i] = lvl_ff[i] ^ active_low_ff;
      end else begin : g_none
         assign pin_press[i] = active_low_ff;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_ovf_ff, rsp_count_ff, rsp_button_ff, rsp_evalid_ff});
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign full       = (count_ff == CW'(QUEUE_DEPTH));
   assign wp_next    = (wp_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
   assign rp_next    = (rp_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_ff + 1'b1;

   assign p_cur   = pin_press[pidx_ff];
   assign chg     = p_cur != raw_ff[pidx_ff];
   assign t_old   = ct_vld_ff[pidx_ff] ? ct_q : '0;
   assign t_eff   = chg ? now_ff : t_old;
   assign elapsed = now_ff - t_eff;
   assign settle  = (elapsed >= {{(mbd_pkg::NOW_W - mbd_pkg::DEB_W){1'b0}}, deb_ff})
                    && (stable_ff[pidx_ff] != p_cur);
   assign push    = settle && p_cur;

   always_comb begin
      state_in      = state_ff;
      btn_in        = btn_ff;
      pvld_in       = pvld_ff;
      pidx_in       = pidx_ff;
      now_in        = now_ff;
      lvl_in        = lvl_ff;
      drop_in       = drop_ff;
      raw_in        = raw_ff;
      stable_in     = stable_ff;
      ct_vld_in     = ct_vld_ff;
      rp_in         = rp_ff;
      wp_in         = wp_ff;
      count_in      = count_ff;
      res_valid_in  = res_valid_ff;
      res_button_in = res_button_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_evalid_in = rsp_evalid_ff;
      rsp_button_in = rsp_button_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      ct_re         = 1'b0;
      ct_we         = 1'b0;
      ct_waddr      = pidx_ff;
      ev_we         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               now_in        = req_tdata[mbd_pkg::NOW_W-1:0];
               lvl_in        = req_tdata[mbd_pkg::NOW_W +: mbd_pkg::LEVEL_BITS];
               btn_in        = '0;
               pvld_in       = 1'b0;
               drop_in       = 1'b0;
               res_valid_in  = 1'b0;
               res_button_in = '0;
               unique case (mbd_pkg::mode_type'(req_tuser))
                  mbd_pkg::MODE_TICK: state_in = ST_TICK;
                  mbd_pkg::MODE_INIT: state_in = ST_INIT;
                  mbd_pkg::MODE_POP:  state_in = (count_ff == '0) ? ST_DONE : ST_POP;
                  default:            state_in = ST_DONE;
               endcase
            end
         end
         ST_TICK: begin
            ct_re   = (btn_ff < BCW'(NUM_BUTTONS));
            pvld_in = ct_re;
            pidx_in = btn_ff[IW-1:0];
            if (ct_re) begin
               btn_in = btn_ff + 1'b1;
            end
            if (pvld_ff) begin
               raw_in[pidx_ff] = p_cur;
               if (chg) begin
                  ct_we              = 1'b1;
                  ct_vld_in[pidx_ff] = 1'b1;
               end
               if (settle) begin
                  stable_in[pidx_ff] = p_cur;
               end
               if (push) begin
                  if (full) begin
                     drop_in = 1'b1;
                  end else begin
                     ev_we    = 1'b1;
                     wp_in    = wp_next;
                     count_in = count_ff + 1'b1;
                  end
               end
            end
            if (!ct_re) begin
               state_in = ST_DONE;
            end
         end
         ST_INIT: begin
            ct_we     = 1'b1;
            ct_waddr  = btn_ff[IW-1:0];
            ct_vld_in = '1;
            raw_in    = pin_press;
            stable_in = pin_press;
            btn_in    = btn_ff + 1'b1;
            if (btn_ff == BCW'(NUM_BUTTONS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_POP: begin
            res_valid_in  = 1'b1;
            res_button_in = ev_q;
            rp_in         = rp_next;
            count_in      = count_ff - 1'b1;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_evalid_in = res_valid_ff;
               rsp_button_in = res_button_ff;
               rsp_count_in  = count_ff;
               rsp_ovf_in    = drop_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         btn_ff        <= '0;
         pvld_ff       <= 1'b0;
         raw_ff        <= '0;
         stable_ff     <= '0;
         ct_vld_ff     <= '0;
         rp_ff         <= '0;
         wp_ff         <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         deb_ff        <= mbd_pkg::DEB_RESET;
         active_low_ff <= mbd_pkg::ACTIVE_LOW_RESET;
      end else begin
         state_ff     <= state_in;
         btn_ff       <= btn_in;
         pvld_ff      <= pvld_in;
         raw_ff       <= raw_in;
         stable_ff    <= stable_in;
         ct_vld_ff    <= ct_vld_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               mbd_pkg::CSR_DEBOUNCE:   deb_ff        <= csr_wdata;
               mbd_pkg::CSR_ACTIVE_LOW: active_low_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
      pidx_ff       <= pidx_in;
      now_ff        <= now_in;
      lvl_ff        <= lvl_in;
      drop_ff       <= drop_in;
      res_valid_ff  <= res_valid_in;
      res_button_ff <= res_button_in;
      rsp_evalid_ff <= rsp_evalid_in;
      rsp_button_ff <= rsp_button_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   always_ff @(posedge clock) begin
      if (ct_re) begin
         ct_q <= ct_mem[btn_ff[IW-1:0]];
      end
      if (ct_we) begin
         ct_mem[ct_waddr] <= now_ff;
      end
   end

   always_ff @(posedge clock) begin
      ev_q <= ev_mem[rp_ff];
      if (ev_we) begin
         ev_mem[wp_ff] <= mbd_pkg::BTN_W'(pidx_ff);
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("event count exceeds queue depth");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wp_ff == rp_ff))
      else $error("empty queue with unequal pointers");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("pop did not decrement the event count");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TICK && pvld_ff && push && !full) |=> (count_ff != '0))
      else $error("accepted press left the queue empty");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished transaction was not presented");

endmodule
